@@ sv/rds_pkg.sv @@
// Shared types and constants for the reaction-diffusion stencil step.
`timescale 1ns / 1ps
package rds_pkg;
	localparam int unsigned DefMaxCells    = 4096;
	localparam int unsigned DefFracBits    = 8;
	localparam logic [16:0] OneQ15         = 17'd32768;
	localparam logic [15:0] HalfQ15        = 16'd16384;
	localparam logic [1:0]  RegDiffusion   = 2'd0;
	localparam logic [1:0]  RegReaction    = 2'd1;
	localparam logic [1:0]  RegUnburned    = 2'd2;
	localparam logic [1:0]  RegBurned      = 2'd3;

	typedef struct packed {
		logic [15:0] cell_value;
		logic        last_cell;
	} in_item_t;

	typedef struct packed {
		logic [11:0] cell_index;
		logic [15:0] new_value;
		logic [15:0] cell_temp;
		logic        end_of_run;
		logic [19:0] front_position;
		logic        run_too_short;
	} out_item_t;

	// Work handed from front to back: one cell to update.
	typedef struct packed {
		logic [1:0]  kind;      // KindFirst, KindInterior, KindLast
		logic [15:0] left;
		logic [15:0] mid;
		logic [15:0] right;
		logic [15:0] index;
	} job_t;

	localparam logic [1:0] KindFirst    = 2'd0;
	localparam logic [1:0] KindInterior = 2'd1;
	localparam logic [1:0] KindLast     = 2'd2;
endpackage

@@ sv/reaction_diffusion_stencil_step.sv @@
// Top level of the reaction-diffusion stencil step.
`timescale 1ns / 1ps
// One explicit Fisher-KPP step over a stream of cells. Cell i's result appears after cell
// i+1 is pushed; the last cell also yields its own result. Interior cells pass through the
// back end as three products through one shared multiplier, rounding, two temperature
// products, the crossing check and the output slot; the first and last cells skip to the
// temperature products. The run's front crossing costs one extra restoring divide at most
// once per run, and a result not yet popped holds the back end. The front holds each cell
// until its jobs, if any, are handed over; a two-entry queue lets it keep taking cells meanwhile.
module reaction_diffusion_stencil_step import rds_pkg::*; #(
	parameter int unsigned MAX_CELLS     = DefMaxCells,
	parameter int unsigned FRACTION_BITS = DefFracBits
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  in_item_t    in_item,
	output logic        empty,
	input  logic        pop,
	output out_item_t   out_item,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	logic [14:0] diff_q;
	logic [15:0] gain_q, tu_q, tb_q;
	logic fj_valid, fj_ready, bj_valid, bj_ready;
	job_t fj, bj;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_q <= 15'd16384;
			gain_q <= 16'd655;
			tu_q   <= 16'd3000;
			tb_q   <= 16'd20000;
		end else if (cfg_valid) begin
			case (cfg_index)
				RegDiffusion: diff_q <= cfg_data[14:0];
				RegReaction:  gain_q <= cfg_data;
				RegUnburned:  tu_q   <= cfg_data;
				RegBurned:    tb_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	rds_front #(.MAX_CELLS(MAX_CELLS)) u_front (.clk, .arst_n, .push, .full, .in_item,
		.job_valid(fj_valid), .job_ready(fj_ready), .job(fj));
	rds_queue u_queue (.clk, .arst_n, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
		.rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj));
	rds_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (.clk, .arst_n, .job_valid(bj_valid),
		.job_ready(bj_ready), .job(bj), .diffusion_number(diff_q), .reaction_gain(gain_q),
		.unburned_temp(tu_q), .burned_temp(tb_q), .empty, .pop, .out_item);
endmodule

@@ sv/rds_front.sv @@
// Front end: line buffer, cell counter and job generation.
`timescale 1ns / 1ps
module rds_front import rds_pkg::*; #(
	parameter int unsigned MAX_CELLS = DefMaxCells
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t in_item,
	output logic     job_valid,
	input  logic     job_ready,
	output job_t     job
);
	localparam int CW = $clog2(MAX_CELLS);

	logic [15:0]   older_q, middle_q, cur_q;
	logic [CW-1:0] count_q;
	logic          last_q;
	logic [1:0]    pend_q;   // jobs still to hand over for the held item: 0..2
	logic          first_q;  // next pending job is the interior/first one

	logic [15:0] sat;
	assign sat = (in_item.cell_value > OneQ15[15:0]) ? 16'd32768 : in_item.cell_value;
	assign full = (pend_q != 2'd0);

	always_comb begin
		job = '0;
		job.left  = older_q;
		job.mid   = middle_q;
		job.right = cur_q;
		if (first_q) begin
			job.kind  = (count_q == CW'(1)) ? KindFirst : KindInterior;
			job.index = 16'(count_q) - 16'd1;
		end else begin
			job.kind  = KindLast;
			job.index = 16'(count_q);
		end
	end
	assign job_valid = (pend_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q  <= '0;
			middle_q <= '0;
			cur_q    <= '0;
			count_q  <= '0;
			last_q   <= 1'b0;
			pend_q   <= '0;
			first_q  <= 1'b0;
		end else if (push && !full) begin
			cur_q  <= sat;
			last_q <= in_item.last_cell;
			first_q <= (count_q != '0);
			pend_q <= 2'((count_q != '0) ? 1 : 0) + 2'(in_item.last_cell);
			// opening cell of a run gives no job: shift it straight in
			if (count_q == '0 && !in_item.last_cell) begin
				older_q  <= middle_q;
				middle_q <= sat;
				count_q  <= CW'(1);
			end
		end else if (job_valid && job_ready) begin
			pend_q  <= pend_q - 2'd1;
			if (pend_q == 2'd1) begin
				if (last_q) begin
					older_q  <= '0;
					middle_q <= '0;
					count_q  <= '0;
				end else begin
					older_q  <= middle_q;
					middle_q <= cur_q;
					if (count_q != CW'(MAX_CELLS - 1))
						count_q <= count_q + CW'(1);
				end
			end
			first_q <= 1'b0;
		end
	end
endmodule

@@ sv/rds_queue.sv @@
// Two-entry job queue between front and back.
`timescale 1ns / 1ps
module rds_queue import rds_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  job_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output job_t rd_data
);
	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_valid && wr_ready)
			mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr_valid && wr_ready)
				wp_q <= ~wp_q;
			if (rd_valid && rd_ready)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
		end
	end
endmodule

@@ sv/rds_back.sv @@
// Back end: shared multiplier, clamp, temperature, crossing divider, output slot.
`timescale 1ns / 1ps
module rds_back import rds_pkg::*; #(
	parameter int unsigned FRACTION_BITS = DefFracBits
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	output logic        job_ready,
	input  job_t        job,
	input  logic [14:0] diffusion_number,
	input  logic [15:0] reaction_gain,
	input  logic [15:0] unburned_temp,
	input  logic [15:0] burned_temp,
	output logic        empty,
	input  logic        pop,
	output out_item_t   out_item
);
	localparam int NW = 16 + FRACTION_BITS;
	localparam logic [3:0] StIdle = 4'd0, StM1 = 4'd1, StM2 = 4'd2, StM3 = 4'd3,
		StRound = 4'd4, StT1 = 4'd5, StT2 = 4'd6, StCross = 4'd7, StDiv = 4'd8,
		StOut = 4'd9;

	logic [3:0]  st_q;
	job_t        job_q;
	logic [15:0] val_q;
	logic signed [49:0] acc_q;
	logic [33:0] tacc_q;
	logic [15:0] prev_q;
	logic [19:0] found_q;
	logic        seen_q;
	logic [NW-1:0] rem_q, quo_q;
	logic [16:0]   den_q;
	logic [5:0]    dcnt_q;
	logic          full_q;
	out_item_t     out_q;

	// Shared multiplier, one product a cycle while the state machine is in a multiply state.
	logic signed [17:0] ma;
	logic signed [33:0] mb;
	logic signed [51:0] mp;
	logic signed [17:0] lap;
	assign lap = 18'(signed'({2'b0, job_q.left})) - 18'(signed'({1'b0, job_q.mid, 1'b0}))
		+ 18'(signed'({2'b0, job_q.right}));
	always_comb begin
		ma = '0;
		mb = '0;
		case (st_q)
			StM1: begin ma = 18'(diffusion_number); mb = 34'(lap); end
			StM2: begin ma = 18'(reaction_gain); mb = 34'(job_q.mid); end
			StM3: begin ma = 18'(32768 - 32'(job_q.mid)); mb = 34'(tacc_q); end
			StT1: begin ma = 18'(unburned_temp); mb = 34'(17'd32768 - 17'(val_q)); end
			StT2: begin ma = 18'(burned_temp); mb = 34'(val_q); end
			default: ;
		endcase
	end
	assign mp = ma * mb;

	logic [50:0] rnd;
	assign rnd = 51'(acc_q) + (51'd1 << 30);

	assign job_ready = (st_q == StIdle);
	assign empty     = !full_q;
	assign out_item  = out_q;

	logic [15:0] idx_m1;
	assign idx_m1 = job_q.index - 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= StIdle;
			prev_q  <= '0;
			found_q <= '0;
			seen_q  <= 1'b0;
			full_q  <= 1'b0;
			job_q   <= '0;
			val_q   <= '0;
			acc_q   <= '0;
			tacc_q  <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			den_q   <= '0;
			dcnt_q  <= '0;
			out_q   <= '0;
		end else begin
			if (pop && full_q && st_q != StOut)
				full_q <= 1'b0;
			case (st_q)
				StIdle: if (job_valid) begin
					job_q <= job;
					case (job.kind)
						KindFirst: begin val_q <= 16'd32768; st_q <= StT1; end
						KindLast: begin val_q <= '0; st_q <= StT1; end
						default: st_q <= StM1;
					endcase
				end
				StM1: begin
					acc_q <= (50'(signed'(mp)) <<< 15)
						+ 50'(signed'({1'b0, job_q.mid, 31'b0}));
					st_q <= StM2;
				end
				StM2: begin
					// k*c kept whole, multiplied by (1-c) next
					tacc_q <= 34'(mp);
					st_q <= StM3;
				end
				StM3: st_q <= StRound;
				StRound: st_q <= StT1;
				StT1: begin tacc_q <= 34'(mp) + 34'd16384; st_q <= StT2; end
				StT2: begin tacc_q <= tacc_q + 34'(mp); st_q <= StCross; end
				StCross: begin
					if (job_q.index != 16'd0 && !seen_q && val_q <= HalfQ15
						&& prev_q > HalfQ15) begin
						rem_q  <= NW'(prev_q - HalfQ15) << FRACTION_BITS;
						den_q  <= 17'(prev_q) - 17'(val_q);
						quo_q  <= '0;
						dcnt_q <= 6'(NW);
						st_q   <= StDiv;
					end else st_q <= StOut;
				end
				StDiv: begin
					if (dcnt_q == 6'd0) begin
						found_q <= 20'((32'(idx_m1) << FRACTION_BITS) + 32'(quo_q));
						seen_q  <= 1'b1;
						st_q    <= StOut;
					end else begin
						// restoring divide, one quotient bit per cycle
						if ((42'(rem_q) >> (dcnt_q - 6'd1)) >= 42'(den_q)) begin
							rem_q <= rem_q - NW'(42'(den_q) << (dcnt_q - 6'd1));
							quo_q <= quo_q | (NW'(1) << (dcnt_q - 6'd1));
						end
						dcnt_q <= dcnt_q - 6'd1;
					end
				end
				StOut: if (!full_q || pop) begin
					out_q.cell_index <= job_q.index[11:0];
					out_q.new_value  <= val_q;
					out_q.cell_temp  <= (tacc_q[33:15] > 19'd65535) ? 16'hFFFF : tacc_q[30:15];
					out_q.end_of_run <= (job_q.kind == KindLast);
					out_q.front_position <= (job_q.kind != KindLast) ? 20'd0
						: seen_q ? found_q
						: (val_q > HalfQ15) ? 20'(32'(job_q.index) << FRACTION_BITS) : 20'd0;
					out_q.run_too_short <= (job_q.kind == KindLast) && (job_q.index < 16'd3);
					if (job_q.kind == KindLast) begin
						prev_q  <= '0;
						found_q <= '0;
						seen_q  <= 1'b0;
					end else prev_q <= val_q;
					full_q <= 1'b1;
					st_q   <= StIdle;
				end
				default: st_q <= StIdle;
			endcase
			// M3 product: (1-c)*(k*c) added to the diffusion sum
			if (st_q == StM3)
				acc_q <= acc_q + 50'(mp);
			if (st_q == StRound)
				val_q <= acc_q[49] ? 16'd0
					: (rnd[50:31] > 20'd32768) ? 16'd32768 : rnd[46:31];
		end
	end

	a_value_le_one: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> out_q.new_value <= 16'd32768)
		else $error("value above one");
	a_kind_known: assert property (@(posedge clk) disable iff (!arst_n)
		(job_q.kind == KindFirst) || (job_q.kind == KindInterior) || (job_q.kind == KindLast))
		else $error("bad job kind");
	a_pos_end_only: assert property (@(posedge clk) disable iff (!arst_n)
		full_q && !out_q.end_of_run |-> out_q.front_position == 20'd0)
		else $error("position off run end");
	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		full_q && !pop |=> full_q && $stable(out_q))
		else $error("waiting beat changed");
endmodule

@@ bench/reaction_diffusion_stencil_step_tb.sv @@
// Self-checking testbench for the reaction-diffusion stencil step.
`timescale 1ns / 1ps
module reaction_diffusion_stencil_step_tb;
	import rds_pkg::*;

	localparam int unsigned FRAC = DefFracBits;
	localparam int unsigned TOP_INDEX = DefMaxCells - 1;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 200;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	in_item_t    in_item;
	logic        empty;
	logic        pop;
	out_item_t   out_item;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	reaction_diffusion_stencil_step dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.empty(empty), .pop(pop), .out_item(out_item), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor copy of registers and stencil state
	logic [14:0] diff_num;
	logic [15:0] react_gain;
	logic [15:0] cold_temp;
	logic [15:0] hot_temp;
	logic [15:0] left_cell;
	logic [15:0] centre_cell;
	logic [11:0] cell_count;
	logic [15:0] prev_value;
	logic [19:0] front_found;
	logic        front_seen;

	in_item_t  cell_queue[$];
	out_item_t expected_cells[$];
	int        failures;
	int        idle_cycles;
	bit        sender_idle_on;
	bit        receiver_idle_on;
	bit        receiver_hold;
	int        hold_count;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic logic [15:0] temp_of_value(input logic [15:0] c);
		logic [63:0] t;
		t = 64'(cold_temp) * (64'd32768 - 64'(c)) + 64'(hot_temp) * 64'(c) + 64'd16384;
		t = t >> 15;
		return (t > 64'd65535) ? 16'hFFFF : t[15:0];
	endfunction

	function automatic logic [15:0] stencil_update(input logic [15:0] l, input logic [15:0] c,
			input logic [15:0] r);
		longint lap;
		longint sum;
		longint v;
		lap = longint'(l) - 2 * longint'(c) + longint'(r);
		sum = longint'(c) * (64'sd1 <<< 31) + longint'(diff_num) * lap * (64'sd1 <<< 15)
			+ longint'(react_gain) * longint'(c) * (32768 - longint'(c));
		if (sum < 0)
			return 16'd0;
		v = (sum + (64'sd1 <<< 30)) >>> 31;
		return (v > 32768) ? 16'd32768 : v[15:0];
	endfunction

	task automatic queue_result(input int unsigned idx, input logic [15:0] val, input bit fin);
		out_item_t r;
		longint unsigned numer;
		longint unsigned pos;
		if (idx > 0 && !front_seen && val <= HalfQ15 && prev_value > HalfQ15) begin
			numer = longint'(prev_value - HalfQ15) << FRAC;
			pos = (longint'(idx - 1) << FRAC) + numer / longint'(prev_value - val);
			front_found = pos[19:0];
			front_seen = 1'b1;
		end
		prev_value = val;
		r = '0;
		r.cell_index = idx[11:0];
		r.new_value = val;
		r.cell_temp = temp_of_value(val);
		r.end_of_run = fin;
		if (fin) begin
			if (front_seen)
				pos = front_found;
			else if (val > HalfQ15)
				pos = longint'(idx) << FRAC;
			else
				pos = 0;
			r.front_position = pos[19:0];
			r.run_too_short = (idx + 1 < 4);
		end
		expected_cells.push_back(r);
	endtask

	task automatic predict_cell(input in_item_t it);
		logic [15:0] cur;
		int unsigned k;
		cur = (it.cell_value > 16'd32768) ? 16'd32768 : it.cell_value;
		k = cell_count;
		if (k == 1)
			queue_result(0, 16'd32768, 1'b0);
		else if (k >= 2)
			queue_result(k - 1, stencil_update(left_cell, centre_cell, cur), 1'b0);
		if (it.last_cell) begin
			queue_result(k, 16'd0, 1'b1);
			left_cell = '0;
			centre_cell = '0;
			cell_count = '0;
			prev_value = '0;
			front_found = '0;
			front_seen = 1'b0;
		end else begin
			left_cell = centre_cell;
			centre_cell = cur;
			if (cell_count < TOP_INDEX)
				cell_count++;
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n && push && !full) begin
			predict_cell(in_item);
			void'(cell_queue.pop_front());
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (cell_queue.size() > 0 && !(sender_idle_on && $urandom_range(99) < 38)) begin
			push <= 1'b1;
			in_item <= cell_queue[0];
		end else begin
			push <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n && pop && !empty) begin
			idle_cycles = 0;
			if (expected_cells.size() == 0) begin
				$display("%0t: unexpected result %p", $time, out_item);
				failures++;
			end else begin
				exp_r = expected_cells.pop_front();
				if (out_item.cell_index !== exp_r.cell_index) begin
					$display("%0t: cell_index expected %0d actual %0d", $time,
						exp_r.cell_index, out_item.cell_index);
					failures++;
				end
				if (out_item.new_value !== exp_r.new_value) begin
					$display("%0t: new_value expected %0d actual %0d", $time,
						exp_r.new_value, out_item.new_value);
					failures++;
				end
				if (out_item.cell_temp !== exp_r.cell_temp) begin
					$display("%0t: cell_temp expected %0d actual %0d", $time,
						exp_r.cell_temp, out_item.cell_temp);
					failures++;
				end
				if (out_item.end_of_run !== exp_r.end_of_run) begin
					$display("%0t: end_of_run expected %0d actual %0d", $time,
						exp_r.end_of_run, out_item.end_of_run);
					failures++;
				end
				if (out_item.front_position !== exp_r.front_position) begin
					$display("%0t: front_position expected %0d actual %0d", $time,
						exp_r.front_position, out_item.front_position);
					failures++;
				end
				if (out_item.run_too_short !== exp_r.run_too_short) begin
					$display("%0t: run_too_short expected %0d actual %0d", $time,
						exp_r.run_too_short, out_item.run_too_short);
					failures++;
				end
			end
		end else if (arst_n && push && !full) begin
			idle_cycles = 0;
		end else if (arst_n) begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
			hold_count <= 0;
		end else if (receiver_hold && hold_count < 300) begin
			pop <= 1'b0;
			hold_count <= hold_count + 1;
		end else begin
			pop <= !(receiver_idle_on && $urandom_range(99) < 38);
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			RegDiffusion: diff_num = val[14:0];
			RegReaction:  react_gain = val;
			RegUnburned:  cold_temp = val;
			default:      hot_temp = val;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (cell_queue.size() > 0 || expected_cells.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic add_cell(input logic [15:0] v, input bit fin);
		in_item_t it;
		it.cell_value = v;
		it.last_cell = fin;
		cell_queue.push_back(it);
	endtask

	// well-formed front profile with noise; occasionally raw noise
	task automatic add_run(input int len);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(9) == 0)
				add_cell(16'($urandom), i == len - 1);
			else if (i < len / 2)
				add_cell(16'(32768 - $urandom_range(3000)), i == len - 1);
			else
				add_cell(16'($urandom_range(3000)), i == len - 1);
		end
	endtask

	initial begin
		int sent;
		failures = 0;
		idle_cycles = 0;
		sender_idle_on = 1'b0;
		receiver_idle_on = 1'b0;
		receiver_hold = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_index = RegDiffusion;
		cfg_data = '0;
		diff_num = 15'd16384;
		react_gain = 16'd655;
		cold_temp = 16'd3000;
		hot_temp = 16'd20000;
		left_cell = '0;
		centre_cell = '0;
		cell_count = '0;
		prev_value = '0;
		front_found = '0;
		front_seen = 1'b0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: single cell, short runs, extremes, saturation
		add_cell(16'd32768, 1'b1);
		add_cell(16'hFFFF, 1'b0);
		add_cell(16'd0, 1'b1);
		add_cell(16'd32768, 1'b0);
		add_cell(16'd32768, 1'b0);
		add_cell(16'd0, 1'b1);
		add_cell(16'd32768, 1'b0);
		add_cell(16'd32768, 1'b0);
		add_cell(16'd20000, 1'b0);
		add_cell(16'd16384, 1'b0);
		add_cell(16'd0, 1'b0);
		add_cell(16'hFFFF, 1'b0);
		add_cell(16'h7FFF, 1'b1);
		add_cell(16'd40000, 1'b0);
		add_cell(16'd30000, 1'b0);
		add_cell(16'd30000, 1'b0);
		add_cell(16'd30000, 1'b1);
		wait_drained();

		write_reg(RegDiffusion, 16'd29491);
		write_reg(RegReaction, 16'hFFFF);
		write_reg(RegUnburned, 16'hFFFF);
		write_reg(RegBurned, 16'hFFFF);
		add_run(8);
		add_run(3);
		wait_drained();
		write_reg(RegDiffusion, 16'd0);
		write_reg(RegReaction, 16'd0);
		write_reg(RegUnburned, 16'd0);
		write_reg(RegBurned, 16'd0);
		add_run(6);
		wait_drained();

		// long hold-off while the sender keeps offering: back-pressure
		receiver_hold = 1'b1;
		add_run(40);
		while (cell_queue.size() > 0)
			@(posedge clk);
		receiver_hold = 1'b0;
		wait_drained();

		write_reg(RegDiffusion, 16'd16384);
		write_reg(RegReaction, 16'd655);
		write_reg(RegUnburned, 16'd3000);
		write_reg(RegBurned, 16'd20000);

		sent = 0;
		for (int phase = 0; phase < 4; phase++) begin
			sender_idle_on = (phase != 1);
			receiver_idle_on = (phase != 1);
			write_reg(RegDiffusion, 16'($urandom_range(29491)));
			write_reg(RegReaction, 16'($urandom));
			write_reg(RegUnburned, 16'($urandom));
			write_reg(RegBurned, 16'($urandom));
			while (sent < (phase + 1) * 190) begin
				int len;
				len = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
				add_run(len);
				sent += len;
			end
			wait_drained();
		end

		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

@@ reaction_diffusion_stencil_step.f @@
sv/rds_pkg.sv
sv/rds_front.sv
sv/rds_queue.sv
sv/rds_back.sv
sv/reaction_diffusion_stencil_step.sv
bench/reaction_diffusion_stencil_step_tb.sv
